FILE: rtl/esc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-32 byte update for the escape stuffer.
// Used by every module of the block; depends on nothing.
package esc_pkg;

    localparam logic [7:0]  ESC_FLAG   = 8'h7E;
    localparam logic [7:0]  ESC_MARK   = 8'h7D;
    localparam logic [7:0]  ESC_FLAG_X = 8'h5E;
    localparam logic [7:0]  ESC_MARK_X = 8'h5D;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One classified input item, as queued between the front and back ends.
    typedef struct packed {
        logic [7:0]  raw;
        logic        esc;
        logic        fin;
        logic [31:0] fcs;
    } t_cmd;

    // Which result of the current item the back end sends next.
    typedef enum logic [2:0] {
        PH_BYTE,
        PH_ESC,
        PH_FCS0,
        PH_FCS1,
        PH_FCS2,
        PH_FCS3
    } t_phase;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/escape_stuffer_crc32_trailer.sv
`timescale 1ns / 1ps
// Top level of the byte stuffer with CRC-32 trailer.
// Depends on esc_pkg, esc_front, esc_cmdq and esc_back.
//
// Usage: the input side is a queue write port. A raw image byte with its
// final flag is transferred on a rising edge where push is high and full is
// low. The output side is a queue read port: while empty is low the oldest
// result sits on the o_ ports, and it is transferred on an edge where pop is
// high. Each byte yields one result, or two when it is 0x7E or 0x7D (sent as
// 0x7D 0x5E and 0x7D 0x5D). A byte marked final is followed by the four bytes
// of the inverted CRC-32, least significant first, flagged as trailer; the
// last one carries stream_end, and the CRC then restarts for the next image.
// A byte's first result passes through the command queue and then the output
// register before it reaches the ports. While pop keeps up, the back end sends
// one result per cycle, so the input rate is one byte per cycle for plain bytes
// and lower for escaped ones, which take two results; a final byte holds the
// back end while its trailer goes out. That output register is the bottleneck.
// A four-entry command queue lets the input keep going while the receiver
// stalls; once it fills, full is raised until pop drains results. Reset empties
// the queue and the output register and sets the CRC accumulator to all ones.
module escape_stuffer_crc32_trailer import esc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_raw_byte,
    input  logic       i_final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_trailer,
    output logic       o_run_last,
    output logic       o_stream_end
);

    logic q_wr;
    logic q_rd;
    logic q_empty;
    t_cmd wr_cmd;
    t_cmd rd_cmd;

    // Front end: CRC accumulation and escape classification at transfer time.
    esc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_raw_byte   (i_raw_byte),
        .i_final_byte (i_final_byte),
        .i_q_full     (full),
        .o_wr         (q_wr),
        .o_cmd        (wr_cmd)
    );

    // Decoupling queue: holds classified bytes until the back end is done.
    esc_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (wr_cmd),
        .i_rd    (q_rd),
        .o_rdata (rd_cmd),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // Back end: walks each command through its results into the output register.
    esc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (rd_cmd),
        .i_q_empty    (q_empty),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_is_trailer (o_is_trailer),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    // The end of an image is always the last result of its byte and a trailer byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_end) |-> (o_is_trailer && o_run_last))
        else $error("stream_end without trailer and run_last");

    // A trailer byte that is not the last is followed at once by another one.
    a_trailer_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_is_trailer && !o_run_last) |=> (!empty && o_is_trailer))
        else $error("trailer sequence broken");

    // An escape mark in the data is always followed by its escaped code.
    a_escape_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_is_trailer && o_out_byte == ESC_MARK) |=>
        (!empty && !o_is_trailer &&
         (o_out_byte == ESC_FLAG_X || o_out_byte == ESC_MARK_X)))
        else $error("escape mark without escaped code");

endmodule

FILE: rtl/esc_front.sv
`timescale 1ns / 1ps
// Front end: accepts raw bytes, runs the CRC-32 and classifies each byte.
// Depends on esc_pkg; feeds esc_cmdq.
module esc_front import esc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_raw_byte,
    input  logic       i_final_byte,
    input  logic       i_q_full,
    output logic       o_wr,
    output t_cmd       o_cmd
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] crc_upd;

    assign o_wr    = i_push && !i_q_full;
    assign crc_upd = crc_byte(r_crc, i_raw_byte);

    always_comb begin
        n_crc = r_crc;
        if (o_wr) begin
            // The final byte closes the image; the next one starts afresh.
            n_crc = i_final_byte ? CRC_INIT : crc_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_cmd.raw = i_raw_byte;
    assign o_cmd.esc = (i_raw_byte == ESC_FLAG) || (i_raw_byte == ESC_MARK);
    assign o_cmd.fin = i_final_byte;
    assign o_cmd.fcs = ~crc_upd;

endmodule

FILE: rtl/esc_cmdq.sv
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on esc_pkg for the command type and depth.
module esc_cmdq import esc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_full,
    output logic o_empty
);

    t_cmd            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_cnt;
    logic            do_wr;
    logic            do_rd;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
        end
    end

endmodule

FILE: rtl/esc_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued command into its output bytes, one per cycle while pop keeps up.
// Depends on esc_pkg; reads from esc_cmdq.
module esc_back import esc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_q_empty,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_is_trailer,
    output logic       o_run_last,
    output logic       o_stream_end
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_trl;
    logic       r_last;
    logic       r_end;

    logic       load;
    logic [7:0] s_byte;
    logic       s_trl;
    logic       s_last;
    logic       s_end;

    assign o_empty = !r_valid;
    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd  = load && s_last;

    // Next phase of the sequencer.
    always_comb begin
        case (r_phase)
            PH_BYTE: n_phase = i_cmd.esc ? PH_ESC : (i_cmd.fin ? PH_FCS0 : PH_BYTE);
            PH_ESC:  n_phase = i_cmd.fin ? PH_FCS0 : PH_BYTE;
            PH_FCS0: n_phase = PH_FCS1;
            PH_FCS1: n_phase = PH_FCS2;
            PH_FCS2: n_phase = PH_FCS3;
            PH_FCS3: n_phase = PH_BYTE;
            default: n_phase = PH_BYTE;
        endcase
    end

    // Byte and flags that the current phase sends.
    always_comb begin
        s_byte = i_cmd.raw;
        s_trl  = 1'b0;
        s_last = 1'b0;
        s_end  = 1'b0;
        case (r_phase)
            PH_BYTE: begin
                s_byte = i_cmd.esc ? ESC_MARK : i_cmd.raw;
                s_last = !i_cmd.esc && !i_cmd.fin;
            end
            PH_ESC: begin
                s_byte = (i_cmd.raw == ESC_FLAG) ? ESC_FLAG_X : ESC_MARK_X;
                s_last = !i_cmd.fin;
            end
            PH_FCS0: begin
                s_byte = i_cmd.fcs[7:0];
                s_trl  = 1'b1;
            end
            PH_FCS1: begin
                s_byte = i_cmd.fcs[15:8];
                s_trl  = 1'b1;
            end
            PH_FCS2: begin
                s_byte = i_cmd.fcs[23:16];
                s_trl  = 1'b1;
            end
            PH_FCS3: begin
                s_byte = i_cmd.fcs[31:24];
                s_trl  = 1'b1;
                s_last = 1'b1;
                s_end  = 1'b1;
            end
            default: begin
                s_byte = i_cmd.raw;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BYTE;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= s_byte;
            r_trl  <= s_trl;
            r_last <= s_last;
            r_end  <= s_end;
        end
    end

    assign o_out_byte   = r_byte;
    assign o_is_trailer = r_trl;
    assign o_run_last   = r_last;
    assign o_stream_end = r_end;

endmodule
